// ===== hw/rtl/csv_numeric_field_checker_core_assert.svh =====
// assertion macros for the checker rtl
`ifndef CSV_NUMERIC_FIELD_CHECKER_CORE_ASSERT_SVH
`define CSV_NUMERIC_FIELD_CHECKER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CSVNFC_ASSERT_IMP(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("csvnfc assertion failed");

// next-cycle implication, checked out of reset
`define CSVNFC_ASSERT_NXT(name, clk, rstn, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("csvnfc assertion failed");

`endif

// ===== hw/rtl/csvnfc_pkg.sv =====
// types and constants of the numeric field checker
`default_nettype none
package csvnfc_pkg;

	localparam logic [2:0] FT_STRING = 3'd0;
	localparam logic [2:0] FT_FLOAT  = 3'd1;
	localparam logic [2:0] FT_BYTE   = 3'd2;
	localparam logic [2:0] FT_UBYTE  = 3'd3;
	localparam logic [2:0] FT_INT    = 3'd4;
	localparam logic [2:0] FT_UINT   = 3'd5;
	localparam logic [2:0] FT_BOOL   = 3'd6;
	// spare code, handled as a signed integer with no range limit
	localparam logic [2:0] FT_SPARE  = 3'd7;

	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [8:0] MAG_SAT   = 9'd256;
	localparam logic [8:0] BOOL_MAX  = 9'd1;
	localparam logic [8:0] BYTE_MAX  = 9'd127;
	localparam logic [8:0] UBYTE_MAX = 9'd255;

	// counts saturate at two
	localparam logic [1:0] CNT_SAT = 2'd2;

	typedef enum logic [3:0] {
		ERR_NONE        = 4'd0,
		ERR_EMPTY       = 4'd1,
		ERR_DOT_FORBID  = 4'd2,
		ERR_TWO_DOTS    = 4'd3,
		ERR_DOT_ALONE   = 4'd4,
		ERR_DOT_FIRST   = 4'd5,
		ERR_DOT_LAST    = 4'd6,
		ERR_MINUS_FORBID = 4'd7,
		ERR_TWO_MINUS   = 4'd8,
		ERR_MINUS_LATE  = 4'd9,
		ERR_MINUS_ALONE = 4'd10,
		ERR_MINUS_LAST  = 4'd11,
		ERR_NON_NUMERIC = 4'd12,
		ERR_BOOL_RANGE  = 4'd13,
		ERR_BYTE_RANGE  = 4'd14,
		ERR_UBYTE_RANGE = 4'd15
	} err_t;

	typedef struct packed {
		logic [1:0] char_count;
		logic [1:0] dot_count;
		logic       dot_at_start;
		logic [1:0] minus_count;
		logic       minus_at_start;
		logic       minus_late;
		logic       bad_char_seen;
		logic [8:0] magnitude;
		logic       digits_stopped;
	} scan_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/csvnfc_in_if.sv =====
// character channel: one beat per field character
`default_nettype none
interface csvnfc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic [2:0] field_type;
	logic       is_last;
	logic       empty_field;

	modport source (output valid, ch, field_type, is_last, empty_field, input ready);
	modport sink (input valid, ch, field_type, is_last, empty_field, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/csvnfc_out_if.sv =====
// result channel: one beat per ended field
`default_nettype none
interface csvnfc_out_if;
	logic       valid;
	logic       ready;
	logic       ok;
	logic [3:0] error_code;

	modport source (output valid, ok, error_code, input ready);
	modport sink (input valid, ok, error_code, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/csvnfc_scan.sv =====
// per-character update of the field flags and magnitude
`default_nettype none
module csvnfc_scan (
	input  csvnfc_pkg::scan_state_t cur,
	input  logic [7:0]              ch,
	input  logic [2:0]              field_type,
	output csvnfc_pkg::scan_state_t nxt
);
	import csvnfc_pkg::*;

	logic        first;
	logic        is_digit;
	logic [11:0] mag_ext;
	logic [11:0] mag_new;

	assign first    = (cur.char_count == 2'd0);
	assign is_digit = ch inside {[CH_ZERO:CH_NINE]};
	// magnitude * 10 + digit
	assign mag_ext  = {3'd0, cur.magnitude};
	assign mag_new  = (mag_ext << 3) + (mag_ext << 1) + {8'd0, ch[3:0]};

	always_comb begin
		nxt = cur;
		if (ch == CH_DOT) begin
			if (cur.dot_count != CNT_SAT) nxt.dot_count = cur.dot_count + 2'd1;
			if (first) nxt.dot_at_start = 1'b1;
			if (field_type != FT_FLOAT) nxt.bad_char_seen = 1'b1;
		end else if (ch == CH_MINUS) begin
			if (cur.minus_count != CNT_SAT) nxt.minus_count = cur.minus_count + 2'd1;
			if (first) nxt.minus_at_start = 1'b1;
			else nxt.minus_late = 1'b1;
		end else if (!is_digit) begin
			nxt.bad_char_seen = 1'b1;
		end
		if (is_digit) begin
			if (!cur.digits_stopped) begin
				nxt.magnitude = (mag_new > {3'd0, MAG_SAT}) ? MAG_SAT : mag_new[8:0];
			end
		end else if (!(ch == CH_MINUS && first)) begin
			// a leading sign does not end the digit run
			nxt.digits_stopped = 1'b1;
		end
		if (cur.char_count != CNT_SAT) nxt.char_count = cur.char_count + 2'd1;
	end
endmodule
`default_nettype wire

// ===== hw/rtl/csvnfc_judge.sv =====
// priority checks on the flags of a finished field
`default_nettype none
module csvnfc_judge (
	input  csvnfc_pkg::scan_state_t st,
	input  logic [2:0]              field_type,
	input  logic [7:0]              last_ch,
	output csvnfc_pkg::err_t        code
);
	import csvnfc_pkg::*;

	logic is_float;
	logic is_bool;
	logic is_uns;
	logic single;

	assign is_float = (field_type == FT_FLOAT);
	assign is_bool  = (field_type == FT_BOOL);
	assign is_uns   = (field_type == FT_UBYTE) || (field_type == FT_UINT);
	assign single   = (st.char_count == 2'd1);

	always_comb begin
		code = ERR_NONE;
		if (!is_float && st.dot_count != 2'd0) begin
			code = ERR_DOT_FORBID;
		end else if (is_float && st.dot_count == CNT_SAT) begin
			code = ERR_TWO_DOTS;
		end else if (is_float && st.dot_at_start && single) begin
			code = ERR_DOT_ALONE;
		end else if (is_float && st.dot_at_start) begin
			code = ERR_DOT_FIRST;
		end else if (is_float && st.dot_count == 2'd1 && last_ch == CH_DOT) begin
			code = ERR_DOT_LAST;
		end else if ((is_bool || is_uns) && st.minus_count != 2'd0) begin
			code = ERR_MINUS_FORBID;
		end else if (!is_bool && !is_uns && st.minus_count == CNT_SAT) begin
			code = ERR_TWO_MINUS;
		end else if (!is_bool && !is_uns && st.minus_late) begin
			code = ERR_MINUS_LATE;
		end else if (!is_bool && !is_uns && st.minus_at_start && single) begin
			code = ERR_MINUS_ALONE;
		end else if (st.bad_char_seen) begin
			code = ERR_NON_NUMERIC;
		end else if (is_bool && (st.minus_at_start ? st.magnitude != 9'd0
				: st.magnitude > BOOL_MAX)) begin
			code = ERR_BOOL_RANGE;
		end else if (field_type == FT_BYTE && st.magnitude > BYTE_MAX) begin
			code = ERR_BYTE_RANGE;
		end else if (field_type == FT_UBYTE && (st.minus_at_start ? st.magnitude != 9'd0
				: st.magnitude > UBYTE_MAX)) begin
			code = ERR_UBYTE_RANGE;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/csv_numeric_field_checker_core.sv =====
// top level of the numeric field checker
// Usage:
//   chars   : one beat per character of a text field, tagged with the
//             field's type; is_last marks the final character, empty_field
//             a field with no characters (that beat ends the field)
//   results : one beat per ended field with ok and error_code; beats that
//             do not end a field give nothing here
//   A beat is registered into the input stage, its flags and the running
//   magnitude are updated there, and a field end then lands in the result
//   register. One character is taken every cycle unless a field end is held
//   in the input stage by a stalled result register.
//   The rate is set by the flag/multiply-by-ten update loop on the field
//   state register.
//   Reset clears both stage valids and the field state; the block is ready
//   once reset is released.
//   When results stalls, the result waits in its register; the input stage
//   still takes characters that do not end a field, and takes one more
//   field end which then waits, after which chars.ready drops.
`default_nettype none
`include "csv_numeric_field_checker_core_assert.svh"
module csv_numeric_field_checker_core (
	input  logic            clk,
	input  logic            arst_n,
	csvnfc_in_if.sink       chars,
	csvnfc_out_if.source    results
);
	import csvnfc_pkg::*;

	logic        valid_s1;
	logic [7:0]  ch_s1;
	logic [2:0]  type_s1;
	logic        last_s1;
	logic        empty_s1;

	scan_state_t state_q;
	scan_state_t state_nxt;
	err_t        judge_code;

	logic        out_valid_q;
	logic        ok_q;
	err_t        code_q;

	logic        out_free;
	logic        ends_s1;
	logic        adv_s1;
	err_t        code_s1;

	assign out_free    = !out_valid_q || results.ready;
	assign ends_s1     = empty_s1 || last_s1;
	assign adv_s1      = valid_s1 && (!ends_s1 || out_free);
	assign chars.ready = !valid_s1 || adv_s1;

	csvnfc_scan u_scan (
		.cur        (state_q),
		.ch         (ch_s1),
		.field_type (type_s1),
		.nxt        (state_nxt)
	);

	csvnfc_judge u_judge (
		.st         (state_nxt),
		.field_type (type_s1),
		.last_ch    (ch_s1),
		.code       (judge_code)
	);

	// empty marker wins over any collected characters
	assign code_s1 = empty_s1 ? ERR_EMPTY : judge_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			ch_s1    <= chars.ch;
			type_s1  <= chars.field_type;
			last_s1  <= chars.is_last;
			empty_s1 <= chars.empty_field;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= ends_s1 ? '0 : state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && ends_s1) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && ends_s1) begin
			ok_q   <= (code_s1 == ERR_NONE);
			code_q <= code_s1;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.ok         = ok_q;
	assign results.error_code = code_q;

	`CSVNFC_ASSERT_IMP(a_ok_matches_code, clk, arst_n,
		out_valid_q, ok_q == (code_q == ERR_NONE))
	`CSVNFC_ASSERT_NXT(a_state_cleared_after_end, clk, arst_n,
		adv_s1 && ends_s1, state_q == '0)
	`CSVNFC_ASSERT_IMP(a_ready_low_only_on_backpressure, clk, arst_n,
		!chars.ready, valid_s1 && ends_s1 && out_valid_q && !results.ready)
	`CSVNFC_ASSERT_NXT(a_stage_holds_when_blocked, clk, arst_n,
		valid_s1 && !adv_s1, valid_s1 && $stable(ch_s1) && $stable(type_s1))
endmodule
`default_nettype wire

// ===== bench/csv_numeric_field_checker_core_tb.sv =====
// testbench of the numeric field checker: predicted verdicts checked beat by beat
`default_nettype none
module csv_numeric_field_checker_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import csvnfc_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam int END_PAUSE   = 8;

	typedef struct {
		logic ok;
		err_t code;
	} verdict_t;

	logic clk;
	logic arst_n;

	csvnfc_in_if  chars_if ();
	csvnfc_out_if results_if ();

	csv_numeric_field_checker_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.results (results_if)
	);

	verdict_t verdict_q[$];
	int       fail_count;
	int       sent_beats;
	int       quiet_cycles;
	logic     idle_en;
	logic     stall_en;

	// scan state of the field being predicted
	logic [1:0] n_chars;
	logic [1:0] n_dots;
	logic       lead_dot;
	logic [1:0] n_minus;
	logic       lead_minus;
	logic       inner_minus;
	logic       junk_seen;
	logic [8:0] value_acc;
	logic       value_frozen;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_scan();
		n_chars      = '0;
		n_dots       = '0;
		lead_dot     = 1'b0;
		n_minus      = '0;
		lead_minus   = 1'b0;
		inner_minus  = 1'b0;
		junk_seen    = 1'b0;
		value_acc    = '0;
		value_frozen = 1'b0;
	endfunction

	// first failing rule of the ended field, type taken from the ending beat
	function automatic err_t grade_field(input logic [2:0] ty, input logic [7:0] tail_ch);
		logic fl;
		logic bl;
		logic un;
		logic one;
		fl  = (ty == FT_FLOAT);
		bl  = (ty == FT_BOOL);
		un  = (ty == FT_UBYTE) || (ty == FT_UINT);
		one = (n_chars == 2'd1);
		if (!fl && n_dots != 2'd0)
			return ERR_DOT_FORBID;
		if (fl) begin
			if (n_dots >= CNT_SAT)
				return ERR_TWO_DOTS;
			if (lead_dot && one)
				return ERR_DOT_ALONE;
			if (lead_dot)
				return ERR_DOT_FIRST;
			if (n_dots == 2'd1 && tail_ch == CH_DOT)
				return ERR_DOT_LAST;
		end
		if ((bl || un) && n_minus != 2'd0)
			return ERR_MINUS_FORBID;
		if (!bl && !un) begin
			if (n_minus >= CNT_SAT)
				return ERR_TWO_MINUS;
			if (inner_minus)
				return ERR_MINUS_LATE;
			if (lead_minus && one)
				return ERR_MINUS_ALONE;
		end
		if (junk_seen)
			return ERR_NON_NUMERIC;
		if (ty == FT_BOOL && (lead_minus ? value_acc != 9'd0 : value_acc > BOOL_MAX))
			return ERR_BOOL_RANGE;
		if (ty == FT_BYTE && value_acc > BYTE_MAX)
			return ERR_BYTE_RANGE;
		if (ty == FT_UBYTE && (lead_minus ? value_acc != 9'd0 : value_acc > UBYTE_MAX))
			return ERR_UBYTE_RANGE;
		return ERR_NONE;
	endfunction

	function automatic void scan_beat(input logic [7:0] c, input logic [2:0] ty,
			input logic last, input logic empty);
		logic     first;
		logic     digit;
		int       nxt;
		verdict_t v;
		if (empty) begin
			clear_scan();
			v.ok   = 1'b0;
			v.code = ERR_EMPTY;
			verdict_q.push_back(v);
			return;
		end
		first = (n_chars == 2'd0);
		digit = (c >= CH_ZERO) && (c <= CH_NINE);
		if (c == CH_DOT) begin
			if (n_dots < CNT_SAT)
				n_dots++;
			if (first)
				lead_dot = 1'b1;
			if (ty != FT_FLOAT)
				junk_seen = 1'b1;
		end else if (c == CH_MINUS) begin
			if (n_minus < CNT_SAT)
				n_minus++;
			if (first)
				lead_minus = 1'b1;
			else
				inner_minus = 1'b1;
		end else if (!digit) begin
			junk_seen = 1'b1;
		end
		if (digit) begin
			if (!value_frozen) begin
				nxt = int'(value_acc) * 10 + int'(c) - int'(CH_ZERO);
				value_acc = (nxt > int'(MAG_SAT)) ? MAG_SAT : nxt[8:0];
			end
		end else if (!(c == CH_MINUS && first)) begin
			value_frozen = 1'b1;
		end
		if (n_chars < CNT_SAT)
			n_chars++;
		if (last) begin
			v.code = grade_field(ty, c);
			v.ok   = (v.code == ERR_NONE);
			clear_scan();
			verdict_q.push_back(v);
		end
	endfunction

	task automatic send_beat(input logic [7:0] c, input logic [2:0] ty,
			input logic last, input logic empty);
		@(negedge clk);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			chars_if.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		chars_if.valid       <= 1'b1;
		chars_if.ch          <= c;
		chars_if.field_type  <= ty;
		chars_if.is_last     <= last;
		chars_if.empty_field <= empty;
		@(posedge clk);
		while (!chars_if.ready)
			@(posedge clk);
		scan_beat(c, ty, last, empty);
		sent_beats++;
	endtask

	task automatic send_field(input string text, input logic [2:0] ty);
		for (int i = 0; i < text.len(); i++)
			send_beat(text[i], ty, i == text.len() - 1, 1'b0);
	endtask

	task automatic test_directed_fields();
		send_beat(8'h00, FT_STRING, 1'b0, 1'b1);
		send_field("1", FT_BOOL);
		send_field("2", FT_BOOL);
		send_field("-", FT_INT);
		send_field(".", FT_FLOAT);
		send_field(".", FT_STRING);
		send_field("1.", FT_FLOAT);
		send_field(".5", FT_FLOAT);
		send_field("..", FT_FLOAT);
		send_field("-1", FT_UBYTE);
		send_field("--", FT_INT);
		send_field("1-", FT_INT);
		send_field("128", FT_BYTE);
		send_field("256", FT_UBYTE);
		send_beat(8'hff, FT_SPARE, 1'b1, 1'b0);
		// only the ending beat's type counts: read as bool
		send_beat("1", FT_INT, 1'b0, 1'b0);
		send_beat("2", FT_BOOL, 1'b1, 1'b0);
		// empty marker after characters discards them
		send_beat("7", FT_UINT, 1'b0, 1'b0);
		send_beat("8", FT_UINT, 1'b0, 1'b1);
	endtask

	// well-formed numbers, many near the range limits
	task automatic test_numeric_fields(input int beats);
		int    stop_at;
		int    val;
		int    pos;
		logic [2:0] ty;
		string text;
		int    limit_vals[10] = '{0, 1, 2, 126, 127, 128, 254, 255, 256, 257};
		stop_at = sent_beats + beats;
		while (sent_beats < stop_at) begin
			ty = 3'($urandom_range(0, 7));
			case ($urandom_range(0, 5))
				0: val = limit_vals[$urandom_range(0, 9)];
				1: val = $urandom_range(0, 9);
				2: val = $urandom_range(0, 999);
				3: val = $urandom_range(1000, 99999999);
				default: val = $urandom_range(0, 300);
			endcase
			text = $sformatf("%0d", val);
			if ($urandom_range(0, 4) == 0)
				text = {"0", text};
			if ($urandom_range(0, 3) == 0)
				text = {"-", text};
			if (ty == FT_FLOAT && text.len() >= 2 && $urandom_range(0, 1) == 1) begin
				pos = $urandom_range(1, text.len() - 1);
				text = {text.substr(0, pos - 1), ".", text.substr(pos, text.len() - 1)};
			end
			send_field(text, ty);
		end
	endtask

	// short fields of digits, dots, minus signs and stray bytes
	task automatic test_malformed_fields(input int beats);
		int         stop_at;
		int         len;
		logic [2:0] ty;
		logic [2:0] beat_ty;
		logic [7:0] c;
		logic       cut;
		stop_at = sent_beats + beats;
		while (sent_beats < stop_at) begin
			ty  = 3'($urandom_range(0, 7));
			len = $urandom_range(1, 5);
			cut = ($urandom_range(0, 9) == 0);
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: c = CH_ZERO + 8'($urandom_range(0, 9));
					5, 6: c = CH_DOT;
					7, 8: c = CH_MINUS;
					default: c = 8'($urandom_range(0, 255));
				endcase
				beat_ty = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : ty;
				send_beat(c, beat_ty, i == len - 1, cut && i == len - 1);
			end
		end
	endtask

	// unconstrained beats, every input bit free
	task automatic test_raw_beats(input int beats);
		int stop_at;
		stop_at = sent_beats + beats;
		while (sent_beats < stop_at)
			send_beat(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
				$urandom_range(0, 2) == 0, $urandom_range(0, 7) == 0);
	endtask

	initial begin : result_sink
		int hold;
		hold = 0;
		results_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold == 0 && stall_en && $urandom_range(0, 6) == 0)
				hold = $urandom_range(1, 10);
			results_if.ready <= (hold == 0);
			if (hold > 0)
				hold--;
		end
	end

	always @(posedge clk) begin : result_check
		verdict_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (verdict_q.size() == 0) begin
				$error("unexpected result: ok=%0b error_code=%0d",
					results_if.ok, results_if.error_code);
				fail_count++;
			end else begin
				want = verdict_q.pop_front();
				if (results_if.ok !== want.ok) begin
					$error("ok: expected %0b, actual %0b", want.ok, results_if.ok);
					fail_count++;
				end
				if (results_if.error_code !== want.code) begin
					$error("error_code: expected %0d, actual %0d",
						want.code, results_if.error_code);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (chars_if.valid && chars_if.ready)
				|| (results_if.valid && results_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		@(posedge arst_n);
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n               = 1'b0;
		chars_if.valid       = 1'b0;
		chars_if.ch          = '0;
		chars_if.field_type  = '0;
		chars_if.is_last     = 1'b0;
		chars_if.empty_field = 1'b0;
		idle_en              = 1'b0;
		stall_en             = 1'b0;
		fail_count           = 0;
		sent_beats           = 0;
		quiet_cycles         = 0;
		clear_scan();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		idle_en  = 1'b1;
		stall_en = 1'b1;
		test_directed_fields();
		test_numeric_fields(500);
		test_malformed_fields(400);
		test_raw_beats(200);
		// closing stretch at full rate
		idle_en  = 1'b0;
		stall_en = 1'b0;
		test_numeric_fields(100);
		test_malformed_fields(100);
		@(negedge clk);
		chars_if.valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (END_PAUSE) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire
